/* hw/rtl/bpa_pkg.sv */
// Shared types and constants of the bitmap page allocator.
`default_nettype none
package bpa_pkg;

  // Used-map row geometry: one row holds the used bits of WORD_W pages.
  localparam int unsigned WORD_W = 32;
  localparam int unsigned OFF_W  = 5;
  localparam int unsigned PAGE_W = 13;

  // Request actions.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_RUN = 2'd1;
  localparam logic [1:0] ST_ZERO   = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  // Outcome of scanning one used-map row.
  typedef struct packed {
    logic              hit;
    logic [OFF_W-1:0]  pos;
    logic [PAGE_W-1:0] run;
  } scan_res_t;

endpackage
`default_nettype wire

/* hw/rtl/bpa_scan.sv */
// First-fit row scanner: finds where a free run reaches the requested length.
`default_nettype none
module bpa_scan (
  input  wire logic [bpa_pkg::WORD_W-1:0] word,
  input  wire logic [bpa_pkg::PAGE_W-1:0] run_in,
  input  wire logic [bpa_pkg::PAGE_W-1:0] count,
  output bpa_pkg::scan_res_t              res
);

  // Per bit position: free-run length ending there, carried over from earlier rows
  // when every bit up to it is free.
  always_comb begin
    int unsigned lu;
    logic        any;
    logic [bpa_pkg::PAGE_W:0]   run_j;
    logic [bpa_pkg::WORD_W-1:0] hit_v;
    logic [bpa_pkg::PAGE_W:0]   run_last;
    hit_v    = '0;
    run_last = '0;
    for (int j = 0; j < bpa_pkg::WORD_W; j++) begin
      lu  = 0;
      any = 1'b0;
      for (int i = 0; i < bpa_pkg::WORD_W; i++) begin
        if (i <= j && word[i]) begin
          any = 1'b1;
          lu  = i;
        end
      end
      if (any) begin
        run_j = (bpa_pkg::PAGE_W + 1)'(j - lu);
      end else begin
        run_j = {1'b0, run_in} + (bpa_pkg::PAGE_W + 1)'(j + 1);
      end
      hit_v[j] = (run_j >= {1'b0, count});
      if (j == bpa_pkg::WORD_W - 1) begin
        run_last = run_j;
      end
    end
    res.hit = |hit_v;
    res.pos = '0;
    for (int k = bpa_pkg::WORD_W - 1; k >= 0; k--) begin
      if (hit_v[k]) begin
        res.pos = bpa_pkg::OFF_W'(k);
      end
    end
    res.run = run_last[bpa_pkg::PAGE_W-1:0];
  end

endmodule
`default_nettype wire

/* hw/rtl/bitmap_page_allocator_top.sv */
// Top level of the bitmap first-fit page allocator.
//
// One used bit per page lives in an on-chip map of 32-bit rows. A transaction
// is taken when start is high and busy is low. An allocate finds the lowest
// run of page_count free pages below min(page_limit, NUM_PAGES), marks it
// used and reports its start page; a free clears page_count bits from
// start_page. Each transaction produces exactly one result, shown on status
// and first_page for the single cycle in which done is high; the receiver
// cannot stall it, so capture it then. Zero-count requests, allocates longer
// than the limit and out-of-range frees finish in the cycle after acceptance.
// An allocate that searches scans rows upward from row 0, one row per cycle,
// up to ceil(limit/32) rows, then reads and rewrites each row the run
// touches; a free reads and rewrites the rows of its run. After reset the
// block is busy while it clears the map; page_limit writes are taken at any
// time, but change it only while idle.
`default_nettype none
module bitmap_page_allocator_top #(
  parameter int unsigned NUM_PAGES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        action,
  input  wire logic [12:0] page_count,
  input  wire logic [11:0] start_page,
  input  wire logic        cfg_we,
  input  wire logic [12:0] cfg_data,
  output logic             done,
  output logic [1:0]       status,
  output logic [11:0]      first_page
);

  localparam int unsigned WORD_W = bpa_pkg::WORD_W;
  localparam int unsigned OFF_W  = bpa_pkg::OFF_W;
  localparam int unsigned PAGE_W = bpa_pkg::PAGE_W;
  localparam int unsigned ROWS   = (NUM_PAGES + WORD_W - 1) / WORD_W;
  localparam int unsigned AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned NP_CAP = (NUM_PAGES > 8191) ? 8191 : NUM_PAGES;
  localparam logic [PAGE_W-1:0] NP_CAP_L = PAGE_W'(NP_CAP);
  localparam logic [AW-1:0]     LAST_ROW = AW'(ROWS - 1);
  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    S_CLEAR   = 6'b000001,
    S_IDLE    = 6'b000010,
    S_SCAN_RD = 6'b000100,
    S_SCAN_EV = 6'b001000,
    S_MARK_RD = 6'b010000,
    S_MARK_WR = 6'b100000
  } state_t;

  state_t state;

  logic [PAGE_W-1:0] page_limit;
  logic [PAGE_W-1:0] eff_limit;
  logic [PAGE_W-1:0] eff_m1;

  logic [AW-1:0]     row;
  logic [31:0]       row32;
  logic [PAGE_W-1:0] run;
  logic [PAGE_W-1:0] count_q;
  logic              set_q;
  logic [PAGE_W-1:0] lo;
  logic [PAGE_W-1:0] last;

  // Used-map memory, one write and one registered read per cycle.
  logic [WORD_W-1:0] mem [ROWS];
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] wr_data;
  logic              wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Clamp the configured limit to the pages the map really holds.
  assign eff_limit = (page_limit > NP_CAP_L) ? NP_CAP_L : page_limit;
  assign eff_m1    = eff_limit - PAGE_W'(1);
  assign row32     = 32'(row);
  assign busy      = (state != S_IDLE);

  // Treat pages at or above the limit as used in the last scanned row.
  logic              at_end_row;
  logic [WORD_W-1:0] tail_mask;
  logic [WORD_W-1:0] scan_word;

  assign at_end_row = (row32 == 32'(eff_m1[PAGE_W-1:OFF_W]));
  assign tail_mask  = (at_end_row && eff_limit[OFF_W-1:0] != '0)
                      ? (ALL_ONES << eff_limit[OFF_W-1:0]) : '0;
  assign scan_word  = rd_data | tail_mask;

  bpa_pkg::scan_res_t scan;

  bpa_scan u_scan (
    .word   (scan_word),
    .run_in (run),
    .count  (count_q),
    .res    (scan)
  );

  // Page where the run reached its length; the run ends there.
  logic [31:0]       hit_page;
  logic [PAGE_W-1:0] hit_lo;
  logic [31:0]       hit_lo_row;

  assign hit_page   = {row32[31-OFF_W:0], scan.pos};
  assign hit_lo     = hit_page[PAGE_W-1:0] + PAGE_W'(1) - count_q;
  assign hit_lo_row = 32'(hit_lo[PAGE_W-1:OFF_W]);

  // Free request range check.
  logic [PAGE_W:0]   free_end;
  logic              free_range;
  logic [PAGE_W-1:0] free_last;
  logic [31:0]       free_lo_row;

  assign free_end    = {2'b00, start_page} + {1'b0, page_count};
  assign free_range  = (free_end > {1'b0, eff_limit});
  assign free_last   = free_end[PAGE_W-1:0] - PAGE_W'(1);
  assign free_lo_row = 32'(start_page[11:OFF_W]);

  // Bit mask of the run within the row being written.
  logic [OFF_W-1:0]  lo_off;
  logic [OFF_W-1:0]  hi_off;
  logic              at_last_row;
  logic [WORD_W-1:0] run_mask;

  assign at_last_row = (row32 == 32'(last[PAGE_W-1:OFF_W]));
  assign lo_off      = (row32 == 32'(lo[PAGE_W-1:OFF_W])) ? lo[OFF_W-1:0] : '0;
  assign hi_off      = at_last_row ? last[OFF_W-1:0] : '1;
  assign run_mask    = (ALL_ONES << lo_off) & (ALL_ONES >> (OFF_W'(WORD_W - 1) - hi_off));

  // Memory port steering.
  always_comb begin
    rd_addr = row;
    wr_addr = row;
    wr_en   = 1'b0;
    wr_data = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_SCAN_EV: begin
        rd_addr = row + AW'(1);
      end
      S_MARK_WR: begin
        rd_addr = row + AW'(1);
        wr_en   = 1'b1;
        wr_data = set_q ? (rd_data | run_mask) : (rd_data & ~run_mask);
      end
      default: begin
        rd_addr = row;
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      row        <= '0;
      page_limit <= PAGE_W'(4096);
      done       <= 1'b0;
      status     <= bpa_pkg::ST_OK;
      first_page <= '0;
      run        <= '0;
      count_q    <= '0;
      set_q      <= 1'b0;
      lo         <= '0;
      last       <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        page_limit <= cfg_data;
      end
      unique case (state)
        S_CLEAR: begin
          if (row == LAST_ROW) begin
            state <= S_IDLE;
          end else begin
            row <= row + AW'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            count_q <= page_count;
            if (action == bpa_pkg::ACT_ALLOC) begin
              set_q <= 1'b1;
              if (page_count == '0) begin
                done       <= 1'b1;
                status     <= bpa_pkg::ST_ZERO;
                first_page <= '0;
              end else if (page_count > eff_limit) begin
                done       <= 1'b1;
                status     <= bpa_pkg::ST_NO_RUN;
                first_page <= '0;
              end else begin
                row   <= '0;
                run   <= '0;
                state <= S_SCAN_RD;
              end
            end else begin
              set_q <= 1'b0;
              if (page_count == '0) begin
                done       <= 1'b1;
                status     <= bpa_pkg::ST_OK;
                first_page <= '0;
              end else if (free_range) begin
                done       <= 1'b1;
                status     <= bpa_pkg::ST_RANGE;
                first_page <= '0;
              end else begin
                lo    <= {1'b0, start_page};
                last  <= free_last;
                row   <= free_lo_row[AW-1:0];
                state <= S_MARK_RD;
              end
            end
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_EV;
        end
        S_SCAN_EV: begin
          if (scan.hit) begin
            lo    <= hit_lo;
            last  <= hit_page[PAGE_W-1:0];
            row   <= hit_lo_row[AW-1:0];
            state <= S_MARK_RD;
          end else if (at_end_row) begin
            done       <= 1'b1;
            status     <= bpa_pkg::ST_NO_RUN;
            first_page <= '0;
            state      <= S_IDLE;
          end else begin
            run <= scan.run;
            row <= row + AW'(1);
          end
        end
        S_MARK_RD: begin
          state <= S_MARK_WR;
        end
        S_MARK_WR: begin
          if (at_last_row) begin
            done       <= 1'b1;
            status     <= bpa_pkg::ST_OK;
            first_page <= set_q ? lo[11:0] : 12'd0;
            state      <= S_IDLE;
          end else begin
            row <= row + AW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result only follows an accepted transaction or work in progress.
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result strobe without a transaction");

  // Failed or free results never report a start page.
  a_fail_zero_page: assert property (@(posedge clk) disable iff (rst)
    (done && status != bpa_pkg::ST_OK) |-> (first_page == 12'd0))
    else $error("nonzero first_page on a failed request");

  // Row writes stay within the run being marked or cleared.
  a_mark_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK_WR) |->
      ((row32 >= 32'(lo[PAGE_W-1:OFF_W])) && (row32 <= 32'(last[PAGE_W-1:OFF_W]))))
    else $error("map write outside the run");

  // No map work starts while the clearing pass runs.
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> busy)
    else $error("idle during clearing pass");

endmodule
`default_nettype wire
